@@ rtl/core/ssm_pkg.sv @@
// shared types, register indexes and constants of the stereo sound mixer
package ssm_pkg;

	localparam int CfgIdxW = 3;
	localparam int CfgDataW = 10;
	localparam int ChanW = 6;
	localparam int MixW = 14;

	typedef enum logic [CfgIdxW-1:0] {
		REG_ROUTING   = 3'd0,
		REG_MASTER    = 3'd1,
		REG_DMA_MIX   = 3'd2,
		REG_BIAS      = 3'd3,
		REG_P1_DUTY   = 3'd4,
		REG_P2_DUTY   = 3'd5,
		REG_WAVE_LVL  = 3'd6
	} reg_idx_t;

	typedef logic signed [ChanW-1:0] chan_t;
	typedef logic signed [MixW-1:0] mix_t;

	localparam logic [7:0] DUTY_PATTERN [4] = '{8'hFE, 8'h7E, 8'h78, 8'h81};

	localparam logic [9:0] BIAS_RESET = 10'd512;
	localparam mix_t BIAS_CENTER = 14'sd512;
	localparam mix_t OUT_MIN = -14'sd512;
	localparam mix_t OUT_MAX = 14'sd511;

	function automatic logic duty_bit(input logic [1:0] duty, input logic [2:0] phase);
		logic [7:0] pat;
		pat = DUTY_PATTERN[duty];
		return pat[phase];
	endfunction

endpackage

@@ rtl/core/stereo_sound_mixer_top.sv @@
// top level of the stereo sound mixer: config registers, input stage, mix and result stage
// One item is taken in every cycle: busy never rises. The item is captured in an input
// register, mixed by a single pass of logic (routing, master volume, legacy shift, dma
// samples, bias, clamp), and the stereo result appears on left_out, right_out and
// channel_status with done high for exactly one cycle, out of the result register that
// follows the mix. The receiver cannot stall the result. Configuration writes are always
// accepted (cfg_ready is high) and take effect on the next item; writes to an index past
// the last register are dropped.
module stereo_sound_mixer_top
	import ssm_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic [3:0]            channel_enables,
	input  logic [2:0]            pulse1_phase,
	input  logic [3:0]            pulse1_volume,
	input  logic [2:0]            pulse2_phase,
	input  logic [3:0]            pulse2_volume,
	input  logic [7:0]            wave_byte,
	input  logic                  wave_low_half,
	input  logic                  noise_bit,
	input  logic [3:0]            noise_volume,
	input  logic signed [7:0]     dma_a_sample,
	input  logic signed [7:0]     dma_b_sample,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CfgIdxW-1:0]    cfg_index,
	input  logic [CfgDataW-1:0]   cfg_data,
	output logic                  done,
	output logic signed [9:0]     left_out,
	output logic signed [9:0]     right_out,
	output logic [3:0]            channel_status
);

	logic [7:0] routing_q;
	logic [6:0] master_q;
	logic [7:0] dma_mix_q;
	logic [9:0] bias_q;
	logic [1:0] p1_duty_q;
	logic [1:0] p2_duty_q;
	logic [2:0] wave_lvl_q;

	logic              valid_s1;
	logic [3:0]        en_s1;
	logic [2:0]        p1_phase_s1;
	logic [3:0]        p1_vol_s1;
	logic [2:0]        p2_phase_s1;
	logic [3:0]        p2_vol_s1;
	logic [7:0]        wave_byte_s1;
	logic              wave_low_s1;
	logic              noise_bit_s1;
	logic [3:0]        noise_vol_s1;
	logic signed [7:0] dma_a_s1;
	logic signed [7:0] dma_b_s1;

	chan_t ch1, ch2, ch3, ch4;
	logic signed [7:0] l_sum, r_sum;
	logic signed [11:0] l_scaled, r_scaled;
	logic signed [11:0] l_shift, r_shift;
	logic [1:0] shamt;
	mix_t dma_a, dma_b, bias;
	mix_t l_mix, r_mix;
	logic signed [9:0] l_clamp, r_clamp;
	reg_idx_t idx;

	assign busy = 1'b0;
	assign cfg_ready = 1'b1;
	assign idx = reg_idx_t'(cfg_index);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			routing_q <= '0;
			master_q <= '0;
			dma_mix_q <= '0;
			bias_q <= BIAS_RESET;
			p1_duty_q <= '0;
			p2_duty_q <= '0;
			wave_lvl_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (idx)
				REG_ROUTING:  routing_q <= cfg_data[7:0];
				REG_MASTER:   master_q <= cfg_data[6:0];
				REG_DMA_MIX:  dma_mix_q <= cfg_data[7:0];
				REG_BIAS:     bias_q <= cfg_data;
				REG_P1_DUTY:  p1_duty_q <= cfg_data[1:0];
				REG_P2_DUTY:  p2_duty_q <= cfg_data[1:0];
				REG_WAVE_LVL: wave_lvl_q <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			en_s1 <= channel_enables;
			p1_phase_s1 <= pulse1_phase;
			p1_vol_s1 <= pulse1_volume;
			p2_phase_s1 <= pulse2_phase;
			p2_vol_s1 <= pulse2_volume;
			wave_byte_s1 <= wave_byte;
			wave_low_s1 <= wave_low_half;
			noise_bit_s1 <= noise_bit;
			noise_vol_s1 <= noise_volume;
			dma_a_s1 <= dma_a_sample;
			dma_b_s1 <= dma_b_sample;
		end
	end

	ssm_voice u_voice (
		.channel_enables (en_s1),
		.pulse1_phase    (p1_phase_s1),
		.pulse1_volume   (p1_vol_s1),
		.pulse2_phase    (p2_phase_s1),
		.pulse2_volume   (p2_vol_s1),
		.wave_byte       (wave_byte_s1),
		.wave_low_half   (wave_low_s1),
		.noise_bit       (noise_bit_s1),
		.noise_volume    (noise_vol_s1),
		.pulse1_duty     (p1_duty_q),
		.pulse2_duty     (p2_duty_q),
		.wave_level      (wave_lvl_q),
		.ch1             (ch1),
		.ch2             (ch2),
		.ch3             (ch3),
		.ch4             (ch4)
	);

	always_comb begin
		r_sum = (routing_q[0] ? 8'(ch1) : 8'sd0) + (routing_q[1] ? 8'(ch2) : 8'sd0)
			+ (routing_q[2] ? 8'(ch3) : 8'sd0) + (routing_q[3] ? 8'(ch4) : 8'sd0);
		l_sum = (routing_q[4] ? 8'(ch1) : 8'sd0) + (routing_q[5] ? 8'(ch2) : 8'sd0)
			+ (routing_q[6] ? 8'(ch3) : 8'sd0) + (routing_q[7] ? 8'(ch4) : 8'sd0);
	end

	assign l_scaled = 12'(l_sum) * $signed({8'd0, master_q[6:4]} + 12'd1);
	assign r_scaled = 12'(r_sum) * $signed({8'd0, master_q[2:0]} + 12'd1);

	// legacy volume three acts as two
	always_comb begin
		case (dma_mix_q[1:0])
			2'd0: shamt = 2'd2;
			2'd1: shamt = 2'd1;
			2'd2: shamt = 2'd0;
			2'd3: shamt = 2'd0;
			default: shamt = 2'd0;
		endcase
	end

	assign l_shift = l_scaled >>> shamt;
	assign r_shift = r_scaled >>> shamt;

	assign dma_a = dma_mix_q[2] ? (mix_t'(dma_a_s1) <<< 2) : (mix_t'(dma_a_s1) <<< 1);
	assign dma_b = dma_mix_q[3] ? (mix_t'(dma_b_s1) <<< 2) : (mix_t'(dma_b_s1) <<< 1);
	assign bias = mix_t'({4'd0, bias_q}) - BIAS_CENTER;

	assign l_mix = mix_t'(l_shift) + (dma_mix_q[4] ? dma_a : '0)
		+ (dma_mix_q[6] ? dma_b : '0) + bias;
	assign r_mix = mix_t'(r_shift) + (dma_mix_q[5] ? dma_a : '0)
		+ (dma_mix_q[7] ? dma_b : '0) + bias;

	assign l_clamp = (l_mix < OUT_MIN) ? 10'(OUT_MIN) :
		((l_mix > OUT_MAX) ? 10'(OUT_MAX) : 10'(l_mix));
	assign r_clamp = (r_mix < OUT_MIN) ? 10'(OUT_MIN) :
		((r_mix > OUT_MAX) ? 10'(OUT_MAX) : 10'(r_mix));

	// result stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			left_out <= l_clamp;
			right_out <= r_clamp;
			channel_status <= en_s1;
		end
	end

endmodule

@@ rtl/core/ssm_voice.sv @@
// signed outputs of the four legacy tone channels for one item
module ssm_voice
	import ssm_pkg::*;
(
	input  logic [3:0] channel_enables,
	input  logic [2:0] pulse1_phase,
	input  logic [3:0] pulse1_volume,
	input  logic [2:0] pulse2_phase,
	input  logic [3:0] pulse2_volume,
	input  logic [7:0] wave_byte,
	input  logic       wave_low_half,
	input  logic       noise_bit,
	input  logic [3:0] noise_volume,
	input  logic [1:0] pulse1_duty,
	input  logic [1:0] pulse2_duty,
	input  logic [2:0] wave_level,
	output chan_t      ch1,
	output chan_t      ch2,
	output chan_t      ch3,
	output chan_t      ch4
);

	logic [3:0] nib;
	chan_t s6;
	logic signed [7:0] s8;
	logic signed [7:0] t8;
	logic signed [7:0] q8;
	chan_t wave_val;
	chan_t p1_mag, p2_mag, n_mag;

	assign p1_mag = chan_t'({2'b00, pulse1_volume});
	assign p2_mag = chan_t'({2'b00, pulse2_volume});
	assign n_mag  = chan_t'({2'b00, noise_volume});

	assign nib = wave_low_half ? wave_byte[3:0] : wave_byte[7:4];
	assign s6  = chan_t'({1'b0, nib, 1'b0}) - chan_t'(6'sd16);
	assign s8  = 8'(s6);
	assign t8  = (s8 <<< 1) + s8;
	// three quarters, truncated toward zero
	assign q8  = t8[7] ? ((t8 + 8'sd3) >>> 2) : (t8 >>> 2);

	always_comb begin
		if (wave_level[2]) begin
			wave_val = chan_t'(q8);
		end else begin
			case (wave_level[1:0])
				2'd0: wave_val = '0;
				2'd1: wave_val = s6;
				2'd2: wave_val = s6 >>> 1;
				2'd3: wave_val = s6 >>> 2;
				default: wave_val = '0;
			endcase
		end
	end

	assign ch1 = !channel_enables[0] ? '0 :
		(duty_bit(pulse1_duty, pulse1_phase) ? p1_mag : -p1_mag);
	assign ch2 = !channel_enables[1] ? '0 :
		(duty_bit(pulse2_duty, pulse2_phase) ? p2_mag : -p2_mag);
	assign ch3 = channel_enables[2] ? wave_val : '0;
	assign ch4 = !channel_enables[3] ? '0 : (noise_bit ? n_mag : -n_mag);

endmodule

@@ rtl/core/ssm_checker.sv @@
// port-level checks of the stereo sound mixer and their bind to the top level
module ssm_checker
	import ssm_pkg::*;
(
	input logic                clk,
	input logic                arst_n,
	input logic                start,
	input logic                busy,
	input logic [3:0]          channel_enables,
	input logic                cfg_ready,
	input logic                done,
	input logic [3:0]          channel_status
);

	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!busy && cfg_ready)
		else $error("mixer refused an item or a register write");

	a_item_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##2 done)
		else $error("item produced no result two cycles later");

	a_no_spurious_result: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, 2))
		else $error("result without a matching item");

	a_status_follows: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> channel_status == $past(channel_enables, 2))
		else $error("channel status does not match the item");

endmodule

bind stereo_sound_mixer_top ssm_checker u_ssm_checker (.*);

@@ tb/tb_top.sv @@
// self-checking testbench for the stereo sound mixer: directed and random ticks, register settings
module tb_top;
	import ssm_pkg::*;

	localparam int STALL_LIMIT = 2000;
	localparam int TICKS_PER_PHASE = 75;
	localparam int RANDOM_PHASES = 8;
	localparam int MAX_REPORTS = 50;
	localparam logic [CfgIdxW-1:0] REG_NONE = 3'd7;
	localparam logic [31:0] DUTY_BITS = {8'h81, 8'h78, 8'h7E, 8'hFE};
	localparam logic signed [7:0] DMA_MIN = 8'sh80;
	localparam logic signed [7:0] DMA_MAX = 8'sh7F;

	typedef struct packed {
		logic hold;
		logic [3:0] enables;
		logic [2:0] p1_phase;
		logic [3:0] p1_vol;
		logic [2:0] p2_phase;
		logic [3:0] p2_vol;
		logic [7:0] wave_byte;
		logic wave_low;
		logic noise_bit;
		logic [3:0] noise_vol;
		logic signed [7:0] dma_a;
		logic signed [7:0] dma_b;
	} tick_t;

	typedef struct packed {
		logic signed [9:0] left;
		logic signed [9:0] right;
		logic [3:0] status;
	} stereo_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	tick_t tick_in = '0;
	logic cfg_valid = 1'b0;
	logic [CfgIdxW-1:0] cfg_index = '0;
	logic [CfgDataW-1:0] cfg_data = '0;
	logic busy;
	logic cfg_ready;
	logic done;
	logic signed [9:0] left_out;
	logic signed [9:0] right_out;
	logic [3:0] channel_status;

	logic [7:0] cfg_routing;
	logic [6:0] cfg_master;
	logic [7:0] cfg_dma;
	logic [9:0] cfg_bias;
	logic [1:0] cfg_duty1;
	logic [1:0] cfg_duty2;
	logic [2:0] cfg_wave;

	tick_t pending_ticks[$];
	stereo_t expected_mix[$];
	tick_t next_tick;
	stereo_t want;
	logic tick_taken = 1'b0;
	int send_idle_pct = 0;
	int ticks_queued = 0;
	int results_seen = 0;
	int stall_cycles = 0;
	int reg_writes = 0;
	int settings_loaded = 1;
	int mismatches = 0;

	stereo_sound_mixer_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.channel_enables(tick_in.enables),
		.pulse1_phase(tick_in.p1_phase),
		.pulse1_volume(tick_in.p1_vol),
		.pulse2_phase(tick_in.p2_phase),
		.pulse2_volume(tick_in.p2_vol),
		.wave_byte(tick_in.wave_byte),
		.wave_low_half(tick_in.wave_low),
		.noise_bit(tick_in.noise_bit),
		.noise_volume(tick_in.noise_vol),
		.dma_a_sample(tick_in.dma_a),
		.dma_b_sample(tick_in.dma_b),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.done(done),
		.left_out(left_out),
		.right_out(right_out),
		.channel_status(channel_status)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	function automatic stereo_t mix_predict(input tick_t t);
		int ch [4];
		int lsum;
		int rsum;
		int nib;
		int wv;
		int a;
		int b;
		int shamt;
		stereo_t o;
		ch = '{default: 0};
		lsum = 0;
		rsum = 0;
		if (t.enables[0]) begin
			ch[0] = DUTY_BITS[{cfg_duty1, t.p1_phase}] ? int'(t.p1_vol) : -int'(t.p1_vol);
		end
		if (t.enables[1]) begin
			ch[1] = DUTY_BITS[{cfg_duty2, t.p2_phase}] ? int'(t.p2_vol) : -int'(t.p2_vol);
		end
		if (t.enables[2]) begin
			nib = t.wave_low ? int'(t.wave_byte[3:0]) : int'(t.wave_byte[7:4]);
			wv = 2 * nib - 16;
			if (cfg_wave[2]) begin
				wv = (3 * wv) / 4;
			end else if (cfg_wave[1:0] == 2'd0) begin
				wv = 0;
			end else begin
				wv = wv >>> (int'(cfg_wave[1:0]) - 1);
			end
			ch[2] = wv;
		end
		if (t.enables[3]) begin
			ch[3] = t.noise_bit ? int'(t.noise_vol) : -int'(t.noise_vol);
		end
		for (int i = 0; i < 4; i++) begin
			if (cfg_routing[i]) rsum += ch[i];
			if (cfg_routing[i+4]) lsum += ch[i];
		end
		lsum = lsum * (int'(cfg_master[6:4]) + 1);
		rsum = rsum * (int'(cfg_master[2:0]) + 1);
		// legacy volume three acts as two
		shamt = (cfg_dma[1:0] == 2'd3) ? 0 : 2 - int'(cfg_dma[1:0]);
		lsum = lsum >>> shamt;
		rsum = rsum >>> shamt;
		a = int'($signed(t.dma_a)) * 2;
		b = int'($signed(t.dma_b)) * 2;
		if (cfg_dma[2]) a = a * 2;
		if (cfg_dma[3]) b = b * 2;
		if (cfg_dma[4]) lsum += a;
		if (cfg_dma[5]) rsum += a;
		if (cfg_dma[6]) lsum += b;
		if (cfg_dma[7]) rsum += b;
		lsum += int'(cfg_bias) - 512;
		rsum += int'(cfg_bias) - 512;
		if (lsum < -512) lsum = -512;
		if (lsum > 511) lsum = 511;
		if (rsum < -512) rsum = -512;
		if (rsum > 511) rsum = 511;
		o.left = lsum[9:0];
		o.right = rsum[9:0];
		o.status = t.enables;
		return o;
	endfunction

	task automatic report_mismatch(input string what);
		if (mismatches < MAX_REPORTS) $display("mismatch at %0t: %s", $time, what);
		mismatches++;
	endtask

	// driver
	always @(negedge clk) begin
		if (arst_n && (!start || tick_taken)) begin
			if (pending_ticks.size() != 0
			    && !(pending_ticks[0].hold && expected_mix.size() != 0)
			    && $urandom_range(0, 99) >= send_idle_pct) begin
				next_tick = pending_ticks.pop_front();
				tick_in <= next_tick;
				start <= 1'b1;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// monitor, register mirror and watchdog
	always @(posedge clk) begin
		tick_taken <= arst_n && start && !busy;
		if (!arst_n) begin
			cfg_routing = '0;
			cfg_master = '0;
			cfg_dma = '0;
			cfg_bias = 10'd512;
			cfg_duty1 = '0;
			cfg_duty2 = '0;
			cfg_wave = '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				reg_writes++;
				case (cfg_index)
					REG_ROUTING: cfg_routing = cfg_data[7:0];
					REG_MASTER: cfg_master = cfg_data[6:0];
					REG_DMA_MIX: cfg_dma = cfg_data[7:0];
					REG_BIAS: cfg_bias = cfg_data;
					REG_P1_DUTY: cfg_duty1 = cfg_data[1:0];
					REG_P2_DUTY: cfg_duty2 = cfg_data[1:0];
					REG_WAVE_LVL: cfg_wave = cfg_data[2:0];
					default: ;
				endcase
			end
			if (start && !busy) expected_mix.push_back(mix_predict(tick_in));
			if (done) begin
				results_seen <= results_seen + 1;
				if (expected_mix.size() == 0) begin
					report_mismatch($sformatf("result %0d with no tick pending", results_seen));
				end else begin
					want = expected_mix.pop_front();
					if (left_out !== want.left)
						report_mismatch($sformatf("result %0d left_out %0d, want %0d",
							results_seen, left_out, want.left));
					if (right_out !== want.right)
						report_mismatch($sformatf("result %0d right_out %0d, want %0d",
							results_seen, right_out, want.right));
					if (channel_status !== want.status)
						report_mismatch($sformatf("result %0d channel_status %h, want %h",
							results_seen, channel_status, want.status));
				end
			end
			if ((start && !busy) || done || (cfg_valid && cfg_ready)) begin
				stall_cycles <= 0;
			end else if (stall_cycles >= STALL_LIMIT) begin
				$display("watchdog: no progress for %0d cycles", STALL_LIMIT);
				$display("FAIL stereo_sound_mixer_top");
				$finish;
			end else begin
				stall_cycles <= stall_cycles + 1;
			end
		end
	end

	task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic apply_setting(input logic [9:0] routing, master, dma, bias,
	                             input logic [9:0] duty1, duty2, wave);
		write_reg(REG_ROUTING, routing);
		write_reg(REG_MASTER, master);
		write_reg(REG_DMA_MIX, dma);
		write_reg(REG_BIAS, bias);
		// index past the register list must be dropped
		write_reg(REG_NONE, 10'($urandom_range(0, 1023)));
		write_reg(REG_P1_DUTY, duty1);
		write_reg(REG_P2_DUTY, duty2);
		write_reg(REG_WAVE_LVL, wave);
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(posedge clk);
		settings_loaded++;
	endtask

	task automatic send(input tick_t t);
		pending_ticks.push_back(t);
		ticks_queued++;
	endtask

	task automatic drain();
		while (results_seen != ticks_queued) @(posedge clk);
	endtask

	function automatic tick_t make_tick(input logic [3:0] en, input logic [2:0] ph1,
	                                    input logic [3:0] v1, input logic [2:0] ph2,
	                                    input logic [3:0] v2, input logic [7:0] wb,
	                                    input logic wl, nb, input logic [3:0] nv,
	                                    input logic signed [7:0] a, b);
		tick_t t;
		t.hold = 1'b0;
		t.enables = en;
		t.p1_phase = ph1;
		t.p1_vol = v1;
		t.p2_phase = ph2;
		t.p2_vol = v2;
		t.wave_byte = wb;
		t.wave_low = wl;
		t.noise_bit = nb;
		t.noise_vol = nv;
		t.dma_a = a;
		t.dma_b = b;
		return t;
	endfunction

	function automatic tick_t random_tick();
		tick_t t;
		t.hold = ($urandom_range(0, 39) == 0);
		t.enables = 4'($urandom_range(0, 15));
		t.p1_phase = 3'($urandom_range(0, 7));
		t.p1_vol = 4'($urandom_range(0, 15));
		t.p2_phase = 3'($urandom_range(0, 7));
		t.p2_vol = 4'($urandom_range(0, 15));
		t.wave_byte = 8'($urandom_range(0, 255));
		t.wave_low = 1'($urandom_range(0, 1));
		t.noise_bit = 1'($urandom_range(0, 1));
		t.noise_vol = 4'($urandom_range(0, 15));
		t.dma_a = 8'($urandom_range(0, 255));
		t.dma_b = 8'($urandom_range(0, 255));
		// loud ticks to reach the clamps
		if ($urandom_range(0, 7) == 0) begin
			t.p1_vol = 4'hF;
			t.p2_vol = 4'hF;
			t.noise_vol = 4'hF;
			t.dma_a = $urandom_range(0, 1) ? DMA_MAX : DMA_MIN;
			t.dma_b = $urandom_range(0, 1) ? DMA_MAX : DMA_MIN;
		end
		return t;
	endfunction

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset values: nothing routed, centered bias
		send(make_tick(4'hF, 3'd7, 4'hF, 3'd7, 4'hF, 8'hFF, 1'b1, 1'b1, 4'hF, DMA_MAX, DMA_MIN));
		send(random_tick());
		drain();

		// everything at maximum, legacy volume three, three-quarter wave, master bit 3 set
		apply_setting(10'h0FF, 10'h07F, 10'h0FF, 10'h3FF, 10'd0, 10'd3, 10'd4);
		send(make_tick(4'h0, 3'd0, 4'h0, 3'd0, 4'h0, 8'h00, 1'b0, 1'b0, 4'h0, 8'sd0, 8'sd0));
		send(make_tick(4'hF, 3'd7, 4'hF, 3'd7, 4'hF, 8'hFF, 1'b1, 1'b1, 4'hF, DMA_MAX, DMA_MAX));
		send(make_tick(4'hF, 3'd0, 4'hF, 3'd4, 4'hF, 8'h00, 1'b0, 1'b0, 4'hF, DMA_MIN, DMA_MIN));
		send(make_tick(4'h4, 3'd0, 4'h0, 3'd0, 4'h0, 8'h0F, 1'b0, 1'b0, 4'h0, 8'sd0, 8'sd0));
		send(make_tick(4'h4, 3'd0, 4'h0, 3'd0, 4'h0, 8'hF0, 1'b1, 1'b0, 4'h0, 8'sd0, 8'sd0));
		send(make_tick(4'h3, 3'd0, 4'h9, 3'd0, 4'h6, 8'h5A, 1'b0, 1'b1, 4'h3, 8'sd1, -8'sd1));
		send(make_tick(4'h8, 3'd1, 4'h2, 3'd5, 4'h3, 8'hA5, 1'b1, 1'b0, 4'hF, 8'sd0, 8'sd0));
		send(make_tick(4'h1, 3'd1, 4'h7, 3'd2, 4'h1, 8'h3C, 1'b0, 1'b1, 4'h5, DMA_MAX, DMA_MIN));
		drain();

		// right side only, shift by one: odd negative sums round down
		apply_setting(10'h00F, 10'h008, 10'h001, 10'h200, 10'd1, 10'd2, 10'd7);
		send(make_tick(4'h8, 3'd0, 4'h0, 3'd0, 4'h0, 8'h00, 1'b0, 1'b0, 4'h1, 8'sd0, 8'sd0));
		send(make_tick(4'h8, 3'd0, 4'h0, 3'd0, 4'h0, 8'h00, 1'b0, 1'b0, 4'h3, 8'sd0, 8'sd0));
		send(make_tick(4'h4, 3'd0, 4'h0, 3'd0, 4'h0, 8'h11, 1'b1, 1'b0, 4'h0, 8'sd0, 8'sd0));
		send(make_tick(4'h1, 3'd0, 4'hF, 3'd0, 4'h0, 8'h00, 1'b0, 1'b0, 4'h0, 8'sd0, 8'sd0));
		send(make_tick(4'h2, 3'd0, 4'h0, 3'd3, 4'h7, 8'h00, 1'b0, 1'b0, 4'h0, 8'sd0, 8'sd0));
		send(random_tick());
		drain();

		// left side only, full scale wave, dma to the left, bias register at zero
		apply_setting(10'h0F0, 10'h070, 10'h052, 10'h000, 10'd3, 10'd0, 10'd1);
		send(make_tick(4'hF, 3'd7, 4'hF, 3'd7, 4'hF, 8'hFF, 1'b0, 1'b1, 4'hF, DMA_MAX, DMA_MAX));
		send(make_tick(4'h0, 3'd0, 4'h0, 3'd0, 4'h0, 8'h00, 1'b0, 1'b0, 4'h0, DMA_MIN, DMA_MIN));
		send(make_tick(4'h4, 3'd0, 4'h0, 3'd0, 4'h0, 8'h00, 1'b0, 1'b0, 4'h0, 8'sd0, 8'sd0));
		send(random_tick());
		send(random_tick());
		drain();

		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			apply_setting(10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)),
				{8'($urandom_range(0, 255)), 2'(ph)},
				(ph == 5) ? 10'd0 : (ph == 6) ? 10'h3FF : 10'($urandom_range(0, 1023)),
				{8'($urandom_range(0, 255)), 2'(ph)},
				{8'($urandom_range(0, 255)), 2'(ph + 1)},
				{7'($urandom_range(0, 127)), 3'(ph)});
			send_idle_pct = (ph % 4 == 1) ? 71 : (ph % 4 == 3) ? 33 : 0;
			for (int k = 0; k < TICKS_PER_PHASE; k++) send(random_tick());
			drain();
		end

		repeat (6) @(posedge clk);
		if (expected_mix.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", expected_mix.size()));
		$display("covered %0d mixed ticks under %0d register settings, %0d register writes",
			results_seen, settings_loaded, reg_writes);
		$display("sender idle at 0, 33 and 71 percent with occasional waits for an empty pipe");
		if (mismatches == 0) begin
			$display("PASS stereo_sound_mixer_top");
		end else begin
			$display("FAIL stereo_sound_mixer_top");
		end
		$finish;
	end

endmodule

@@ stereo_sound_mixer_top.f @@
rtl/core/ssm_pkg.sv
rtl/core/ssm_voice.sv
rtl/core/stereo_sound_mixer_top.sv
rtl/core/ssm_checker.sv
tb/tb_top.sv
